/* rtl/core/mrht_pkg.sv */
// Package with shared types and constants of the hash table.
`timescale 1ns / 1ps
package mrht_pkg;

  localparam int MaxRows  = 6;
  localparam int RowDepth = 256;
  localparam int KeyBits  = 32;
  localparam int DataBits = 32;

  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 32;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_FIND   = 2'd1,
    REQ_WRITE  = 2'd2,
    REQ_READ   = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    CFG_ACTIVE_ROWS = 3'd0,
    CFG_MOD_ROW0    = 3'd1,
    CFG_MOD_ROW1    = 3'd2,
    CFG_MOD_ROW2    = 3'd3,
    CFG_MOD_ROW3    = 3'd4,
    CFG_MOD_ROW4    = 3'd5,
    CFG_MOD_ROW5    = 3'd6,
    CFG_EMPTY_KEY   = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MOD_START,
    ST_MOD_WAIT,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_FETCH_RD,
    ST_FETCH_CHK,
    ST_WRITE,
    ST_READ_RD,
    ST_READ_CHK,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] search_key;
    logic [31:0] hash_value;
    logic [2:0]  row_index;
    logic [7:0]  col_index;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic        key_exists;
    logic [2:0]  found_row;
    logic [7:0]  found_col;
    logic [31:0] entry_key;
    logic [31:0] entry_data;
    logic [2:0]  next_row;
    logic [7:0]  next_col;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxBits-1:0]  idx;
    logic [CfgDataBits-1:0] data;
  } cfg_t;

endpackage

/* rtl/core/mrht_if.sv */
// Valid/ready channel interfaces for requests, responses and configuration.
`timescale 1ns / 1ps
interface mrht_req_if;
  logic             valid;
  logic             ready;
  mrht_pkg::req_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mrht_rsp_if;
  logic             valid;
  logic             ready;
  mrht_pkg::rsp_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mrht_cfg_if;
  logic             valid;
  logic             ready;
  mrht_pkg::cfg_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/mrht_modu.sv */
// Bit-serial remainder of a 32-bit hash by a 9-bit modulus.
`timescale 1ns / 1ps
module mrht_modu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [8:0]  divisor_i,
  output logic        busy_o,
  output logic [8:0]  rem_o
);

  logic [31:0] shf_q, shf_d;
  logic [9:0]  rem_q, rem_d;
  logic [8:0]  div_q, div_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [9:0]  trial;

  always_comb begin
    shf_d = shf_q;
    rem_d = rem_q;
    div_d = div_q;
    cnt_d = cnt_q;
    trial = {rem_q[8:0], shf_q[31]};
    if (start_i) begin
      shf_d = dividend_i;
      rem_d = '0;
      div_d = divisor_i;
      cnt_d = 6'd32;
    end else if (cnt_q != 6'd0) begin
      shf_d = {shf_q[30:0], 1'b0};
      rem_d = (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shf_q <= shf_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o = (cnt_q != 6'd0);
  assign rem_o  = rem_q[8:0];

endmodule

/* rtl/core/mrht_store.sv */
// Key and data memories with registered synchronous read.
`timescale 1ns / 1ps
module mrht_store #(
  parameter int Depth    = mrht_pkg::MaxRows * mrht_pkg::RowDepth,
  parameter int KeyBits  = mrht_pkg::KeyBits,
  parameter int DataBits = mrht_pkg::DataBits
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [KeyBits-1:0]       wkey_i,
  input  logic [DataBits-1:0]      wdata_i,
  output logic [KeyBits-1:0]       rkey_o,
  output logic [DataBits-1:0]      rdata_o
);

  logic [KeyBits-1:0]  key_mem  [Depth];
  logic [DataBits-1:0] data_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[addr_i]  <= wkey_i;
      data_mem[addr_i] <= wdata_i;
    end
    rkey_o  <= key_mem[addr_i];
    rdata_o <= data_mem[addr_i];
  end

endmodule

/* rtl/core/multi_row_modulo_hash_table.sv */
// Top level of the multi-row modulo hash table with control sequencer.
//
// Channel  Dir  Handshake    Contents
// req      in   valid/ready  req_type, search_key, hash_value, row/col, write_data
// rsp      out  valid/ready  hit, key_exists, found position, entry, next position
// cfg      in   valid/ready  register index and write data
//
// After reset all MaxRows*RowDepth entries of the key and data memories are cleared,
// one entry a cycle, while no request is taken.
// A lookup or find probes the active rows in turn: it starts the serial remainder
// unit, waits while it runs, then reads the memory and compares the key. A find that
// ends on a free slot reads it back before it responds. A write passes ST_WRITE and a
// read ST_READ_RD and ST_READ_CHK before the response is valid in ST_OUT.
// One request is in flight at a time; the response register holds under stall.
`timescale 1ns / 1ps
module multi_row_modulo_hash_table #(
  parameter int MaxRows  = mrht_pkg::MaxRows,
  parameter int RowDepth = mrht_pkg::RowDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  mrht_req_if.sink   req,
  mrht_rsp_if.source rsp,
  mrht_cfg_if.sink   cfg
);

  localparam int Depth   = MaxRows * RowDepth;
  localparam int AddrW   = $clog2(Depth);
  localparam int ColW    = $clog2(RowDepth);

  mrht_pkg::state_e state_q, state_d;
  mrht_pkg::req_t   rq_q, rq_d;
  mrht_pkg::rsp_t   out_q, out_d;

  logic [2:0]  act_q;
  logic [8:0]  mod_q [MaxRows];
  logic [31:0] ekey_q;

  logic [2:0]  r_q, r_d;
  logic [ColW-1:0] c_q, c_d;
  logic        he_q, he_d;
  logic [2:0]  er_q, er_d;
  logic [ColW-1:0] ec_q, ec_d;
  logic [AddrW-1:0] clr_q, clr_d;

  logic [2:0]  nrows;
  logic [8:0]  mod_eff;
  logic        mstart, mbusy;
  logic [8:0]  mrem;
  logic        we;
  logic [AddrW-1:0] addr;
  logic [31:0] wkey, wdat, rkey, rdat;
  logic        pos_ok;
  logic [2:0]  nr;
  logic [7:0]  nc;

  assign nrows = (act_q > 3'(MaxRows)) ? 3'(MaxRows) : act_q;

  always_comb begin
    mod_eff = mod_q[r_q];
    if (mod_eff == 9'd0) mod_eff = 9'd1;
    if ({1'b0, mod_eff} > 10'(RowDepth)) mod_eff = 9'(RowDepth);
  end

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 3'd6;
      ekey_q <= '0;
      for (int i = 0; i < MaxRows; i++) mod_q[i] <= 9'd256;
    end else if (cfg.valid) begin
      unique case (mrht_pkg::cfg_idx_e'(cfg.payload.idx))
        mrht_pkg::CFG_ACTIVE_ROWS: act_q <= cfg.payload.data[2:0];
        mrht_pkg::CFG_MOD_ROW0, mrht_pkg::CFG_MOD_ROW1, mrht_pkg::CFG_MOD_ROW2,
        mrht_pkg::CFG_MOD_ROW3, mrht_pkg::CFG_MOD_ROW4, mrht_pkg::CFG_MOD_ROW5: begin
          for (int i = 0; i < MaxRows; i++) begin
            if (cfg.payload.idx == 3'(i + 1)) mod_q[i] <= cfg.payload.data[8:0];
          end
        end
        mrht_pkg::CFG_EMPTY_KEY: ekey_q <= cfg.payload.data;
        default: ;
      endcase
    end
  end

  mrht_modu u_modu (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mstart),
    .dividend_i (rq_q.hash_value),
    .divisor_i  (mod_eff),
    .busy_o     (mbusy),
    .rem_o      (mrem)
  );

  mrht_store #(.Depth(Depth)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wkey_i  (wkey),
    .wdata_i (wdat),
    .rkey_o  (rkey),
    .rdata_o (rdat)
  );

  assign pos_ok = (rq_q.row_index < nrows) && ({1'b0, rq_q.col_index} < 9'(RowDepth));

  always_comb begin
    nr = rq_q.row_index;
    nc = rq_q.col_index + 8'd1;
    if ({1'b0, rq_q.col_index} + 9'd1 >= 9'(RowDepth)) begin
      nc = '0;
      nr = rq_q.row_index + 3'd1;
    end
    if (nr >= nrows) begin
      nr = 3'(MaxRows);
      nc = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mrht_pkg::ST_CLEAR:
        if (clr_q == AddrW'(Depth - 1)) state_d = mrht_pkg::ST_IDLE;
      mrht_pkg::ST_IDLE:
        if (req.valid) begin
          if (req.payload.req_type == mrht_pkg::REQ_WRITE) state_d = mrht_pkg::ST_WRITE;
          else if (req.payload.req_type == mrht_pkg::REQ_READ)
            state_d = mrht_pkg::ST_READ_RD;
          else state_d = mrht_pkg::ST_MOD_START;
        end
      mrht_pkg::ST_MOD_START:
        state_d = (r_q < nrows) ? mrht_pkg::ST_MOD_WAIT
                : (he_q ? mrht_pkg::ST_FETCH_RD : mrht_pkg::ST_OUT);
      mrht_pkg::ST_MOD_WAIT:  if (!mbusy) state_d = mrht_pkg::ST_PROBE_RD;
      mrht_pkg::ST_PROBE_RD:  state_d = mrht_pkg::ST_PROBE_CHK;
      mrht_pkg::ST_PROBE_CHK:
        state_d = (rkey == rq_q.search_key) ? mrht_pkg::ST_OUT : mrht_pkg::ST_MOD_START;
      mrht_pkg::ST_FETCH_RD:  state_d = mrht_pkg::ST_FETCH_CHK;
      mrht_pkg::ST_FETCH_CHK: state_d = mrht_pkg::ST_OUT;
      mrht_pkg::ST_WRITE:     state_d = mrht_pkg::ST_OUT;
      mrht_pkg::ST_READ_RD:   state_d = mrht_pkg::ST_READ_CHK;
      mrht_pkg::ST_READ_CHK:  state_d = mrht_pkg::ST_OUT;
      mrht_pkg::ST_OUT:       if (rsp.ready) state_d = mrht_pkg::ST_IDLE;
      default:                state_d = mrht_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rq_d   = rq_q;
    out_d  = out_q;
    r_d    = r_q;
    c_d    = c_q;
    he_d   = he_q;
    er_d   = er_q;
    ec_d   = ec_q;
    clr_d  = clr_q;
    mstart = 1'b0;
    we     = 1'b0;
    addr   = AddrW'(r_q) * AddrW'(RowDepth) + AddrW'(c_q);
    wkey   = rq_q.search_key;
    wdat   = rq_q.write_data;
    req.ready = (state_q == mrht_pkg::ST_IDLE);
    unique case (state_q)
      mrht_pkg::ST_CLEAR: begin
        we    = 1'b1;
        addr  = clr_q;
        wkey  = '0;
        wdat  = '0;
        clr_d = clr_q + AddrW'(1);
      end
      mrht_pkg::ST_IDLE: begin
        rq_d  = req.payload;
        r_d   = '0;
        he_d  = 1'b0;
        out_d = '0;
      end
      mrht_pkg::ST_MOD_START: mstart = (r_q < nrows);
      mrht_pkg::ST_MOD_WAIT:  c_d = ColW'(mrem);
      mrht_pkg::ST_PROBE_CHK: begin
        if (rkey == rq_q.search_key) begin
          out_d = '{hit: 1'b1, key_exists: 1'b1, found_row: r_q, found_col: 8'(c_q),
                    entry_key: rkey, entry_data: rdat, next_row: '0, next_col: '0};
        end else begin
          if (rq_q.req_type == mrht_pkg::REQ_FIND && !he_q && rkey == ekey_q) begin
            he_d = 1'b1;
            er_d = r_q;
            ec_d = c_q;
          end
          r_d = r_q + 3'd1;
        end
      end
      mrht_pkg::ST_FETCH_RD: begin
        r_d = er_q;
        c_d = ec_q;
        addr = AddrW'(er_q) * AddrW'(RowDepth) + AddrW'(ec_q);
      end
      mrht_pkg::ST_FETCH_CHK:
        out_d = '{hit: 1'b1, key_exists: 1'b0, found_row: r_q, found_col: 8'(c_q),
                  entry_key: rkey, entry_data: rdat, next_row: '0, next_col: '0};
      mrht_pkg::ST_WRITE: begin
        addr = AddrW'(rq_q.row_index) * AddrW'(RowDepth) + AddrW'(rq_q.col_index);
        if (pos_ok) begin
          we    = 1'b1;
          out_d = '{hit: 1'b1, key_exists: 1'b0, found_row: rq_q.row_index,
                    found_col: rq_q.col_index, entry_key: rq_q.search_key,
                    entry_data: rq_q.write_data, next_row: '0, next_col: '0};
        end
      end
      mrht_pkg::ST_READ_RD:
        addr = AddrW'(rq_q.row_index) * AddrW'(RowDepth) + AddrW'(rq_q.col_index);
      mrht_pkg::ST_READ_CHK: begin
        if (pos_ok)
          out_d = '{hit: 1'b1, key_exists: 1'b0, found_row: rq_q.row_index,
                    found_col: rq_q.col_index, entry_key: rkey, entry_data: rdat,
                    next_row: nr, next_col: nc};
        else
          out_d = '{hit: 1'b0, key_exists: 1'b0, found_row: '0, found_col: '0,
                    entry_key: '0, entry_data: '0, next_row: rq_q.row_index,
                    next_col: rq_q.col_index};
      end
      default: ;
    endcase
  end

  assign rsp.valid   = (state_q == mrht_pkg::ST_OUT);
  assign rsp.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrht_pkg::ST_CLEAR;
      clr_q   <= '0;
      r_q     <= '0;
      he_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      r_q     <= r_d;
      he_q    <= he_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rq_q  <= rq_d;
    out_q <= out_d;
    c_q   <= c_d;
    er_q  <= er_d;
    ec_q  <= ec_d;
  end

  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mrht_pkg::ST_CLEAR |-> !req.ready) else $error("request taken during clear");
  a_one_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.ready |=> !rsp.valid) else $error("response repeated");
  a_probe_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mrht_pkg::ST_PROBE_RD |-> r_q < nrows) else $error("probe past active rows");
  a_hit_exists: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.payload.key_exists |-> rsp.payload.hit) else $error("exists without hit");

endmodule

/* verif/multi_row_modulo_hash_table_test.sv */
// Self-checking testbench of the multi-row modulo hash table.
`timescale 1ns / 1ps
module multi_row_modulo_hash_table_test;

  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mrht_req_if req_ch ();
  mrht_rsp_if rsp_ch ();
  mrht_cfg_if cfg_ch ();

  multi_row_modulo_hash_table u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_ch.sink),
    .rsp   (rsp_ch.source),
    .cfg   (cfg_ch.sink)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  typedef struct {
    mrht_pkg::req_t req;
    logic has_rsp;
    mrht_pkg::rsp_t rsp;
  } stim_row_t;

  logic [31:0] tbl_key [mrht_pkg::MaxRows*mrht_pkg::RowDepth];
  logic [31:0] tbl_data[mrht_pkg::MaxRows*mrht_pkg::RowDepth];
  logic [2:0]  rows_reg;
  logic [8:0]  mod_reg[mrht_pkg::MaxRows];
  logic [31:0] free_key;

  mrht_pkg::rsp_t rsp_pending[$];
  int   errors;
  int   req_count;
  int   rsp_count;
  int   idle_cycles;
  int   stall_mode;

  function automatic mrht_pkg::rsp_t table_answer(mrht_pkg::req_t r);
    mrht_pkg::rsp_t o;
    int nrows, m, c, idx, er, ec, nr, nc;
    bit have_empty;
    o = '0;
    nrows = (rows_reg > mrht_pkg::MaxRows) ? mrht_pkg::MaxRows : rows_reg;
    have_empty = 0;
    er = 0;
    ec = 0;
    if (r.req_type == mrht_pkg::REQ_LOOKUP || r.req_type == mrht_pkg::REQ_FIND) begin
      for (int i = 0; i < nrows; i++) begin
        m = mod_reg[i];
        if (m == 0) m = 1;
        if (m > mrht_pkg::RowDepth) m = mrht_pkg::RowDepth;
        c = r.hash_value % m;
        idx = i * mrht_pkg::RowDepth + c;
        if (tbl_key[idx] == r.search_key) begin
          o.hit = 1;
          o.key_exists = 1;
          o.found_row = i;
          o.found_col = c;
          o.entry_key = tbl_key[idx];
          o.entry_data = tbl_data[idx];
          return o;
        end
        if (r.req_type == mrht_pkg::REQ_FIND && !have_empty && tbl_key[idx] == free_key)
        begin
          have_empty = 1;
          er = i;
          ec = c;
        end
      end
      if (have_empty) begin
        idx = er * mrht_pkg::RowDepth + ec;
        o.hit = 1;
        o.found_row = er;
        o.found_col = ec;
        o.entry_key = tbl_key[idx];
        o.entry_data = tbl_data[idx];
      end
      return o;
    end
    idx = r.row_index * mrht_pkg::RowDepth + r.col_index;
    if (r.row_index >= nrows) begin
      if (r.req_type == mrht_pkg::REQ_READ) begin
        o.next_row = r.row_index;
        o.next_col = r.col_index;
      end
      return o;
    end
    o.hit = 1;
    o.found_row = r.row_index;
    o.found_col = r.col_index;
    if (r.req_type == mrht_pkg::REQ_WRITE) begin
      tbl_key[idx] = r.search_key;
      tbl_data[idx] = r.write_data;
      o.entry_key = r.search_key;
      o.entry_data = r.write_data;
      return o;
    end
    o.entry_key = tbl_key[idx];
    o.entry_data = tbl_data[idx];
    nr = r.row_index;
    nc = r.col_index + 1;
    if (nc >= mrht_pkg::RowDepth) begin
      nc = 0;
      nr = nr + 1;
    end
    if (nr >= nrows) begin
      nr = mrht_pkg::MaxRows;
      nc = 0;
    end
    o.next_row = nr;
    o.next_col = nc;
    return o;
  endfunction

  task automatic write_reg(mrht_pkg::cfg_idx_e idx, logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= '{idx: idx, data: value};
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      mrht_pkg::CFG_ACTIVE_ROWS: rows_reg = value[2:0];
      mrht_pkg::CFG_EMPTY_KEY:   free_key = value;
      default:                   mod_reg[idx - mrht_pkg::CFG_MOD_ROW0] = value[8:0];
    endcase
  endtask

  task automatic drain_requests();
    while (rsp_pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic send_request(mrht_pkg::req_t r, logic has_rsp, mrht_pkg::rsp_t given);
    mrht_pkg::rsp_t predicted;
    if ($urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    predicted = table_answer(r);
    if (has_rsp && predicted != given) begin
      $error("directed row disagrees with predictor: typed %h, predicted %h", given, predicted);
      errors++;
    end
    rsp_pending.push_back(has_rsp ? given : predicted);
    req_count++;
  endtask

  task automatic send_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic mrht_pkg::req_t random_request(int key_span);
    mrht_pkg::req_t r;
    r.req_type = mrht_pkg::req_type_e'($urandom_range(0, 3));
    r.search_key = (key_span == 0) ? $urandom() : $urandom_range(0, key_span);
    r.hash_value = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 600);
    r.row_index = $urandom_range(0, 7);
    r.col_index = $urandom_range(0, 255);
    r.write_data = $urandom();
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= ($urandom_range(0, 1) == 0);
        default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_count++;
        if (rsp_pending.size() == 0) begin
          $error("response with no request waiting: %h", rsp_ch.payload);
          errors++;
        end else begin
          automatic mrht_pkg::rsp_t e = rsp_pending.pop_front();
          automatic mrht_pkg::rsp_t a = rsp_ch.payload;
          if (a.hit != e.hit) begin
            $error("hit: expected %0d actual %0d", e.hit, a.hit); errors++;
          end
          if (a.key_exists != e.key_exists) begin
            $error("key_exists: expected %0d actual %0d", e.key_exists, a.key_exists);
            errors++;
          end
          if (a.found_row != e.found_row) begin
            $error("found_row: expected %0d actual %0d", e.found_row, a.found_row);
            errors++;
          end
          if (a.found_col != e.found_col) begin
            $error("found_col: expected %0d actual %0d", e.found_col, a.found_col);
            errors++;
          end
          if (a.entry_key != e.entry_key) begin
            $error("entry_key: expected %h actual %h", e.entry_key, a.entry_key); errors++;
          end
          if (a.entry_data != e.entry_data) begin
            $error("entry_data: expected %h actual %h", e.entry_data, a.entry_data);
            errors++;
          end
          if (a.next_row != e.next_row) begin
            $error("next_row: expected %0d actual %0d", e.next_row, a.next_row); errors++;
          end
          if (a.next_col != e.next_col) begin
            $error("next_col: expected %0d actual %0d", e.next_col, a.next_col); errors++;
          end
        end
      end
    end
  end

  // The watchdog limit is large enough that the clearing pass after reset does not trip it.
  always @(posedge clk_i) begin
    if (rst_ni && idle_cycles > WatchdogLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  stim_row_t directed[$];

  function automatic mrht_pkg::req_t mk(mrht_pkg::req_type_e t, logic [31:0] k,
                                        logic [31:0] h, logic [2:0] r, logic [7:0] c,
                                        logic [31:0] d);
    mrht_pkg::req_t q;
    q.req_type = t;
    q.search_key = k;
    q.hash_value = h;
    q.row_index = r;
    q.col_index = c;
    q.write_data = d;
    return q;
  endfunction

  function automatic mrht_pkg::rsp_t mr(logic h, logic e, logic [2:0] fr, logic [7:0] fc,
                                        logic [31:0] k, logic [31:0] d, logic [2:0] nr,
                                        logic [7:0] nc);
    mrht_pkg::rsp_t o;
    o = '{h, e, fr, fc, k, d, nr, nc};
    return o;
  endfunction

  initial begin
    int phase_items;
    mrht_pkg::req_t r;
    mrht_pkg::rsp_t none;
    none = '0;
    errors = 0;
    req_count = 0;
    rsp_count = 0;
    idle_cycles = 0;
    stall_mode = 0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    foreach (tbl_key[i]) begin
      tbl_key[i] = '0;
      tbl_data[i] = '0;
    end
    rows_reg = 3'd6;
    foreach (mod_reg[i]) mod_reg[i] = 9'd256;
    free_key = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{
      '{mk(mrht_pkg::REQ_LOOKUP, 32'h0, 32'h0, 0, 0, 0), 1, mr(1, 1, 0, 0, 0, 0, 0, 0)},
      '{mk(mrht_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0), 1, none},
      '{mk(mrht_pkg::REQ_FIND, 32'h1234, 32'hFFFF_FFFF, 0, 0, 0), 1,
        mr(1, 0, 0, 8'hFF, 0, 0, 0, 0)},
      '{mk(mrht_pkg::REQ_READ, 0, 0, 5, 255, 0), 1, mr(1, 0, 5, 255, 0, 0, 6, 0)},
      '{mk(mrht_pkg::REQ_READ, 0, 0, 0, 255, 0), 1, mr(1, 0, 0, 255, 0, 0, 1, 0)},
      '{mk(mrht_pkg::REQ_READ, 0, 0, 7, 200, 0), 1, mr(0, 0, 0, 0, 0, 0, 7, 200)},
      '{mk(mrht_pkg::REQ_WRITE, 32'hFFFF_FFFF, 0, 6, 0, 32'h1), 1, none},
      '{mk(mrht_pkg::REQ_WRITE, 32'hFFFF_FFFF, 0, 5, 255, 32'hFFFF_FFFF), 1,
        mr(1, 0, 5, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0)},
      '{mk(mrht_pkg::REQ_WRITE, 32'hAAAA_5555, 32'h0, 0, 7, 32'h5555_AAAA), 1,
        mr(1, 0, 0, 7, 32'hAAAA_5555, 32'h5555_AAAA, 0, 0)},
      '{mk(mrht_pkg::REQ_LOOKUP, 32'hAAAA_5555, 32'd7, 0, 0, 0), 0, none},
      '{mk(mrht_pkg::REQ_FIND, 32'hAAAA_5555, 32'd263, 0, 0, 0), 0, none},
      '{mk(mrht_pkg::REQ_READ, 0, 0, 0, 7, 0), 0, none},
      '{mk(mrht_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'd255, 0, 0, 0), 0, none}
    };
    foreach (directed[i]) send_request(directed[i].req, directed[i].has_rsp,
                                       directed[i].rsp);
    req_ch.valid <= 1'b0;
    drain_requests();

    // A zero row count is tried first; then mostly small moduli and a nonzero empty key make collisions likely.
    write_reg(mrht_pkg::CFG_ACTIVE_ROWS, 3'd0);
    send_request(mk(mrht_pkg::REQ_FIND, 0, 5, 0, 0, 0), 1, none);
    send_request(mk(mrht_pkg::REQ_READ, 0, 0, 0, 0, 0), 1, mr(0, 0, 0, 0, 0, 0, 0, 0));
    req_ch.valid <= 1'b0;
    drain_requests();
    write_reg(mrht_pkg::CFG_ACTIVE_ROWS, 3'd7);
    write_reg(mrht_pkg::CFG_MOD_ROW0, 9'd0);
    write_reg(mrht_pkg::CFG_MOD_ROW1, 9'h1FF);
    write_reg(mrht_pkg::CFG_MOD_ROW2, 9'd3);
    write_reg(mrht_pkg::CFG_MOD_ROW3, 9'd1);
    write_reg(mrht_pkg::CFG_MOD_ROW4, 9'd5);
    write_reg(mrht_pkg::CFG_MOD_ROW5, 9'd2);
    write_reg(mrht_pkg::CFG_EMPTY_KEY, 32'hFFFF_FFFF);
    send_request(mk(mrht_pkg::REQ_FIND, 32'hFFFF_FFFF, 9, 0, 0, 0), 0, none);
    send_request(mk(mrht_pkg::REQ_LOOKUP, 32'h0, 9, 0, 0, 0), 0, none);

    for (int ph = 0; ph < 8; ph++) begin
      stall_mode = ph % 3;
      phase_items = 200;
      for (int n = 0; n < phase_items; n++) begin
        r = random_request((ph % 2 == 0) ? 15 : 0);
        if (r.req_type == mrht_pkg::REQ_LOOKUP || r.req_type == mrht_pkg::REQ_FIND) begin
          r.hash_value = (ph % 2 == 0) ? $urandom_range(0, 40) : r.hash_value;
        end
        if ($urandom_range(0, 9) < 8) r.row_index = $urandom_range(0, 5);
        if (n % 32 == 0 && ph != 3) begin
          repeat ($urandom_range(0, 12)) send_idle();
        end
        send_request(r, 0, none);
      end
      req_ch.valid <= 1'b0;
      drain_requests();
      write_reg(mrht_pkg::CFG_ACTIVE_ROWS, $urandom_range(1, 6));
      write_reg(mrht_pkg::CFG_MOD_ROW0, (ph == 4) ? 9'd256 : $urandom_range(1, 16));
      write_reg(mrht_pkg::CFG_MOD_ROW1, $urandom_range(1, 256));
      write_reg(mrht_pkg::CFG_MOD_ROW2, $urandom_range(0, 8));
      write_reg(mrht_pkg::CFG_MOD_ROW3, $urandom_range(1, 256));
      write_reg(mrht_pkg::CFG_MOD_ROW4, $urandom_range(1, 4));
      write_reg(mrht_pkg::CFG_MOD_ROW5, (ph == 6) ? 9'd1 : $urandom_range(1, 511));
      write_reg(mrht_pkg::CFG_EMPTY_KEY, (ph % 2 == 0) ? $urandom_range(0, 15) : $urandom());
    end
    drain_requests();
    $display("Run covered %0d requests and %0d responses under several register settings,",
             req_count, rsp_count);
    $display("with bursty requests and stalled responses.");
    if (errors == 0 && rsp_pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/mrht_pkg.sv
rtl/core/mrht_if.sv
rtl/core/mrht_modu.sv
rtl/core/mrht_store.sv
rtl/core/multi_row_modulo_hash_table.sv
verif/multi_row_modulo_hash_table_test.sv
